[rtl/shku_pkg.sv]
// Shared types, codes and constants of the scalar heading Kalman update unit.
`default_nettype none

package shku_pkg;

    // Field and bus widths
    localparam int CMD_W      = 2;
    localparam int HEAD_W     = 32;
    localparam int YAW_W      = 31;
    localparam int VAR_W      = 64;
    localparam int ANG_W      = 35;   // working angle width, room for sums of three angles
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 96;
    localparam int MUL_W      = 33;
    localparam int DIV_STEPS  = 33;   // quotient bits 32 down to 0
    localparam int DIV_CNT_W  = 6;

    // Measurement sources
    localparam logic [CMD_W-1:0] SRC_RTK   = 2'd0;
    localparam logic [CMD_W-1:0] SRC_MAG   = 2'd1;
    localparam logic [CMD_W-1:0] SRC_DRIVE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_NOISE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RTK_NOISE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAG_NOISE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_NOISE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAG_ENABLE    = 3'd4;

    // Configuration reset values (Q16.48)
    localparam logic [VAR_W-1:0] PROCESS_NOISE_RST = 64'd281474977;
    localparam logic [VAR_W-1:0] RTK_NOISE_RST     = 64'd2814749767;
    localparam logic [VAR_W-1:0] MAG_NOISE_RST     = 64'd2814749767106560;
    localparam logic [VAR_W-1:0] DRIVE_NOISE_RST   = 64'd28147497671;
    localparam logic [VAR_W-1:0] ONE_Q48           = 64'd1 << 48;

    // Angle constants
    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q28_W = (PI_Q60 + 64'h80000000) >> 32;
    localparam logic [63:0] DEG2RAD_W = ((PI_Q60 >> 22) + 64'd90) / 64'd180;
    localparam logic [MUL_W-1:0] DEG2RAD = MUL_W'(DEG2RAD_W);

    localparam logic signed [ANG_W-1:0] PI_ANG     = ANG_W'(PI_Q28_W);
    localparam logic signed [ANG_W-1:0] TWO_PI_ANG = ANG_W'(2 * PI_Q28_W);

    localparam int DEG_SCALE = 1 << 22;
    localparam logic signed [ANG_W-1:0] DEG90_ANG  = ANG_W'(90 * DEG_SCALE);
    localparam logic signed [ANG_W-1:0] DEG180_ANG = ANG_W'(180 * DEG_SCALE);
    localparam logic signed [ANG_W-1:0] DEG360_ANG = ANG_W'(360 * DEG_SCALE);

    localparam logic [2*MUL_W-1:0] ROUND_HALF = 66'h80000000;

    // Datapath commands
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_DEG_INIT,
        DP_RAD_DRIVE,
        DP_DEG_MOD,
        DP_DEG_FOLD,
        DP_DEG_MUL,
        DP_RAD_DEG,
        DP_RAD_MOD,
        DP_DELTA,
        DP_NORM_LOAD,
        DP_NORM_STEP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_GAIN_MUL,
        DP_X_INIT,
        DP_X_DONE,
        DP_MUL_PL,
        DP_MUL_PH,
        DP_P_DONE,
        DP_RESULT
    } dp_cmd_t;

    // Datapath status toward the controller
    typedef struct packed {
        logic gate;        // captured item updates the filter
        logic drive;       // captured item is a drive-forward heading
        logic norm_busy;   // P or R still at or above 2^31
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DEG_MOD0,
        ST_DEG_MOD1,
        ST_DEG_FOLD,
        ST_DEG_MUL,
        ST_DEG_RAD,
        ST_DLT_MOD0,
        ST_DLT_MOD1,
        ST_DELTA,
        ST_NORM_LOAD,
        ST_NORM,
        ST_DIV,
        ST_GAIN,
        ST_X_INIT,
        ST_X_MOD0,
        ST_X_MOD1,
        ST_X_DONE,
        ST_MUL_PL,
        ST_MUL_PH,
        ST_P_DONE,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

[rtl/shku_ctrl.sv]
// Sequencing state machine of the heading Kalman update.
`default_nettype none

module shku_ctrl
    import shku_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         dp_cmd
);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;
    logic                 div_last;

    assign out_free = !m_valid_reg || m_tready;
    assign div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_CHECK;
            ST_CHECK: begin
                if (!status.gate)      state_next = ST_RESULT;
                else if (status.drive) state_next = ST_DLT_MOD0;
                else                   state_next = ST_DEG_MOD0;
            end
            ST_DEG_MOD0:  state_next = ST_DEG_MOD1;
            ST_DEG_MOD1:  state_next = ST_DEG_FOLD;
            ST_DEG_FOLD:  state_next = ST_DEG_MUL;
            ST_DEG_MUL:   state_next = ST_DEG_RAD;
            ST_DEG_RAD:   state_next = ST_DLT_MOD0;
            ST_DLT_MOD0:  state_next = ST_DLT_MOD1;
            ST_DLT_MOD1:  state_next = ST_DELTA;
            ST_DELTA:     state_next = ST_NORM_LOAD;
            ST_NORM_LOAD: state_next = ST_NORM;
            ST_NORM: begin
                if (!status.norm_busy) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last) state_next = ST_GAIN;
            end
            ST_GAIN:      state_next = ST_X_INIT;
            ST_X_INIT:    state_next = ST_X_MOD0;
            ST_X_MOD0:    state_next = ST_X_MOD1;
            ST_X_MOD1:    state_next = ST_X_DONE;
            ST_X_DONE:    state_next = ST_MUL_PL;
            ST_MUL_PL:    state_next = ST_MUL_PH;
            ST_MUL_PH:    state_next = ST_P_DONE;
            ST_P_DONE:    state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        dp_cmd   = DP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) dp_cmd = DP_LOAD;
            end
            ST_CHECK:     dp_cmd = status.drive ? DP_RAD_DRIVE : DP_DEG_INIT;
            ST_DEG_MOD0:  dp_cmd = DP_DEG_MOD;
            ST_DEG_MOD1:  dp_cmd = DP_DEG_MOD;
            ST_DEG_FOLD:  dp_cmd = DP_DEG_FOLD;
            ST_DEG_MUL:   dp_cmd = DP_DEG_MUL;
            ST_DEG_RAD:   dp_cmd = DP_RAD_DEG;
            ST_DLT_MOD0:  dp_cmd = DP_RAD_MOD;
            ST_DLT_MOD1:  dp_cmd = DP_RAD_MOD;
            ST_DELTA:     dp_cmd = DP_DELTA;
            ST_NORM_LOAD: dp_cmd = DP_NORM_LOAD;
            ST_NORM:      dp_cmd = status.norm_busy ? DP_NORM_STEP : DP_DIV_INIT;
            ST_DIV:       dp_cmd = DP_DIV_STEP;
            ST_GAIN:      dp_cmd = DP_GAIN_MUL;
            ST_X_INIT:    dp_cmd = DP_X_INIT;
            ST_X_MOD0:    dp_cmd = DP_RAD_MOD;
            ST_X_MOD1:    dp_cmd = DP_RAD_MOD;
            ST_X_DONE:    dp_cmd = DP_X_DONE;
            ST_MUL_PL:    dp_cmd = DP_MUL_PL;
            ST_MUL_PH:    dp_cmd = DP_MUL_PH;
            ST_P_DONE:    dp_cmd = DP_P_DONE;
            ST_RESULT:    if (out_free) dp_cmd = DP_RESULT;
            default:      dp_cmd = DP_NOP;
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/shku_datapath.sv]
// Datapath: config registers, angle wrap, normalize, divider, multiplier, filter state.
`default_nettype none

module shku_datapath
    import shku_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               dp_cmd,
    output dp_status_t                 status,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [CMD_W-1:0]      in_src,
    input  wire logic [HEAD_W-1:0]     in_head,
    input  wire logic [YAW_W-1:0]      in_yaw,
    input  wire logic                  in_imu_ok,
    input  wire logic                  in_fix_ok,
    output logic [YAW_W-1:0]           out_offset,
    output logic [VAR_W-1:0]           out_var,
    output logic                       out_updated
);

    // config
    logic [VAR_W-1:0] pn_reg, rtk_reg, mag_reg, drv_reg;
    logic             mag_en_reg;

    // captured item
    logic [CMD_W-1:0]         src_reg;
    logic signed [HEAD_W-1:0] head_reg;
    logic signed [YAW_W-1:0]  yaw_reg;
    logic                     imu_ok_reg, fix_reg;

    // filter state
    logic signed [YAW_W-1:0] offset_reg;
    logic [VAR_W-1:0]        var_reg;

    // working registers
    logic signed [ANG_W-1:0] acc_reg;
    logic                    neg_reg;
    logic signed [YAW_W-1:0] delta_reg;
    logic [VAR_W-1:0]        p_reg, r_reg;
    logic [31:0]             den_reg;
    logic [MUL_W-1:0]        rem_reg, k_reg;
    logic [31:0]             lo_reg;
    logic [2*MUL_W-1:0]      prod_reg;

    // result register
    logic [YAW_W-1:0] res_off_reg;
    logic [VAR_W-1:0] res_var_reg;
    logic             res_upd_reg;

    logic signed [ANG_W-1:0] head_ext, yaw_ext, off_ext, delta_ext;
    logic signed [ANG_W-1:0] innov, acc_abs_s, innov_abs_s, rnd_ext, signed_rnd;
    logic [2*MUL_W-1:0]      rnd_sum;
    logic [MUL_W-1:0]        mul_a, mul_b, j_val;
    logic [VAR_W:0]          pred_sum;
    logic [VAR_W-1:0]        pred_var, noise_sel;
    logic [MUL_W:0]          trial;
    logic                    qbit;
    logic [31:0]             rem_keep;

    function automatic logic signed [ANG_W-1:0] mod_step(
        input logic signed [ANG_W-1:0] x,
        input logic signed [ANG_W-1:0] m
    );
        logic signed [ANG_W-1:0] y;
        priority if (x < 0)  y = x + m;
        else if (x >= m)     y = x - m;
        else                 y = x;
        return y;
    endfunction

    assign head_ext  = ANG_W'(head_reg);
    assign yaw_ext   = ANG_W'(yaw_reg);
    assign off_ext   = ANG_W'(offset_reg);
    assign delta_ext = ANG_W'(delta_reg);
    assign innov     = delta_ext - off_ext;

    assign acc_abs_s   = acc_reg[ANG_W-1] ? -acc_reg : acc_reg;
    assign innov_abs_s = innov[ANG_W-1] ? -innov : innov;

    // rounded high half of the product, sign applied from neg_reg
    assign rnd_sum    = prod_reg + ROUND_HALF;
    assign rnd_ext    = ANG_W'(rnd_sum[63:32]);
    assign signed_rnd = neg_reg ? -rnd_ext : rnd_ext;

    assign j_val = (MUL_W'(1) << 32) - k_reg;

    always_comb begin
        unique case (src_reg)
            SRC_RTK:   noise_sel = rtk_reg;
            SRC_MAG:   noise_sel = mag_reg;
            default:   noise_sel = drv_reg;
        endcase
    end

    // predict with saturation
    assign pred_sum = {1'b0, var_reg} + {1'b0, pn_reg};
    assign pred_var = pred_sum[VAR_W] ? '1 : pred_sum[VAR_W-1:0];

    // restoring divide step
    assign trial    = {1'b0, rem_reg} - {2'b0, den_reg};
    assign qbit     = (den_reg != '0) && !trial[MUL_W];
    assign rem_keep = qbit ? trial[31:0] : rem_reg[31:0];

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (dp_cmd)
            DP_DEG_MUL: begin
                mul_a = acc_abs_s[MUL_W-1:0];
                mul_b = DEG2RAD;
            end
            DP_GAIN_MUL: begin
                mul_a = innov_abs_s[MUL_W-1:0];
                mul_b = k_reg;
            end
            DP_MUL_PL: begin
                mul_a = {1'b0, var_reg[31:0]};
                mul_b = {1'b0, j_val[31:0]};
            end
            DP_MUL_PH: begin
                mul_a = {1'b0, var_reg[63:32]};
                mul_b = {1'b0, j_val[31:0]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_reg     <= PROCESS_NOISE_RST;
            rtk_reg    <= RTK_NOISE_RST;
            mag_reg    <= MAG_NOISE_RST;
            drv_reg    <= DRIVE_NOISE_RST;
            mag_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PROCESS_NOISE: pn_reg     <= cfg_wdata;
                REG_RTK_NOISE:     rtk_reg    <= cfg_wdata;
                REG_MAG_NOISE:     mag_reg    <= cfg_wdata;
                REG_DRIVE_NOISE:   drv_reg    <= cfg_wdata;
                REG_MAG_ENABLE:    mag_en_reg <= cfg_wdata[0];
                default:           mag_en_reg <= mag_en_reg;
            endcase
        end
    end

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            var_reg    <= ONE_Q48;
        end else begin
            unique case (dp_cmd)
                DP_DELTA:  var_reg    <= pred_var;
                DP_X_DONE: offset_reg <= YAW_W'(acc_reg - PI_ANG);
                DP_P_DONE: if (k_reg != '0) var_reg <= prod_reg[63:0] + {32'b0, lo_reg};
                default:   offset_reg <= offset_reg;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (dp_cmd)
            DP_LOAD: begin
                src_reg    <= in_src;
                head_reg   <= in_head;
                yaw_reg    <= in_yaw;
                imu_ok_reg <= in_imu_ok;
                fix_reg    <= in_fix_ok;
            end
            DP_DEG_INIT:  acc_reg <= (src_reg == SRC_RTK) ? -head_ext : DEG90_ANG - head_ext;
            DP_RAD_DRIVE: acc_reg <= head_ext - yaw_ext + PI_ANG;
            DP_DEG_MOD:   acc_reg <= mod_step(acc_reg, DEG360_ANG);
            DP_DEG_FOLD:  if (acc_reg > DEG180_ANG) acc_reg <= acc_reg - DEG360_ANG;
            DP_DEG_MUL: begin
                neg_reg  <= acc_reg[ANG_W-1];
                prod_reg <= mul_a * mul_b;
            end
            DP_RAD_DEG:   acc_reg <= signed_rnd - yaw_ext + PI_ANG;
            DP_RAD_MOD:   acc_reg <= mod_step(acc_reg, TWO_PI_ANG);
            DP_DELTA:     delta_reg <= YAW_W'(acc_reg - PI_ANG);
            DP_NORM_LOAD: begin
                p_reg <= var_reg;
                r_reg <= noise_sel;
            end
            DP_NORM_STEP: begin
                p_reg <= p_reg >> 1;
                r_reg <= r_reg >> 1;
            end
            DP_DIV_INIT: begin
                den_reg <= p_reg[31:0] + r_reg[31:0];
                rem_reg <= MUL_W'(p_reg[31:0]);
                k_reg   <= '0;
            end
            DP_DIV_STEP: begin
                rem_reg <= {rem_keep, 1'b0};
                k_reg   <= {k_reg[MUL_W-2:0], qbit};
            end
            DP_GAIN_MUL: begin
                neg_reg  <= innov[ANG_W-1];
                prod_reg <= mul_a * mul_b;
            end
            DP_X_INIT:    acc_reg <= off_ext + signed_rnd + PI_ANG;
            DP_MUL_PL:    prod_reg <= mul_a * mul_b;
            DP_MUL_PH: begin
                lo_reg   <= prod_reg[63:32];
                prod_reg <= mul_a * mul_b;
            end
            default:      lo_reg <= lo_reg;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (dp_cmd == DP_RESULT) begin
            res_off_reg <= offset_reg;
            res_var_reg <= var_reg;
            res_upd_reg <= status.gate;
        end
    end

    assign status.gate = imu_ok_reg && ((src_reg == SRC_RTK && fix_reg)
                                     || (src_reg == SRC_MAG && mag_en_reg)
                                     || (src_reg == SRC_DRIVE));
    assign status.drive     = (src_reg == SRC_DRIVE);
    assign status.norm_busy = (|p_reg[VAR_W-1:31]) || (|r_reg[VAR_W-1:31]);

    assign out_offset  = res_off_reg;
    assign out_var     = res_var_reg;
    assign out_updated = res_upd_reg;

endmodule

`default_nettype wire

[rtl/scalar_heading_kalman_update_unit.sv]
// Top level of the scalar heading Kalman update unit: controller, datapath, ports.
// A non-updating item skips the update: after the check its result is registered.
// An updating item walks the wrap, predict, normalize, bit-serial divide and correct states;
// compass headings first convert degrees to radians. P and R get 0..33 normalizing shifts.
// One item at a time; a new transaction is taken the cycle after the result is registered.
// Reset (aresetn, synchronous, low): X = 0, P = 1.0, noise registers to defaults, outputs idle.
`default_nettype none

module scalar_heading_kalman_update_unit
    import shku_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // measurement stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // heading_meas [31:0], imu_yaw [62:32], imu_valid [63], fix_ok [64], zero fill
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // cmd [1:0]
    input  wire logic [CMD_W-1:0]      s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // offset_est [30:0], offset_var [94:31], zero fill
    output logic [M_TDATA_W-1:0]       m_tdata,
    // updated [0]
    output logic                       m_tuser
);

    dp_cmd_t          dp_cmd;
    dp_status_t       dp_status;
    logic [YAW_W-1:0] res_offset;
    logic [VAR_W-1:0] res_var;
    logic             res_updated;

    // Sequencer: walks wrap, predict, normalize, divide and correct steps
    shku_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .dp_cmd   (dp_cmd)
    );

    // Arithmetic, filter state and the result register that decouples the output side
    shku_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dp_cmd      (dp_cmd),
        .status      (dp_status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_src      (s_tuser),
        .in_head     (s_tdata[31:0]),
        .in_yaw      (s_tdata[62:32]),
        .in_imu_ok   (s_tdata[63]),
        .in_fix_ok   (s_tdata[64]),
        .out_offset  (res_offset),
        .out_var     (res_var),
        .out_updated (res_updated)
    );

    assign m_tdata = {1'b0, res_var, res_offset};
    assign m_tuser = res_updated;

    // The unit is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while an item is in work");

    // Delivered offset lies in [-pi, pi)
    a_offset_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed({{4{m_tdata[30]}}, m_tdata[30:0]}) >= -PI_ANG)
                  && ($signed({{4{m_tdata[30]}}, m_tdata[30:0]}) < PI_ANG))
        else $error("offset estimate outside the wrapped range");

    // Divider starts only on operands that fit its 31-bit inputs
    a_div_normalized: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd == DP_DIV_INIT |-> !dp_status.norm_busy)
        else $error("gain divide started before P and R were normalized");

endmodule

`default_nettype wire
